### rtl/tmhq_pkg.sv
// ----------------------------------------------------------------------------
// tmhq_pkg: shared types and codes for the ternary min-heap queue
// Opcodes, status codes and the stored entry layout.
// ----------------------------------------------------------------------------
package tmhq_pkg;

  localparam int KeyW  = 32;
  localparam int NameW = 16;
  localparam int PosW  = 8;
  localparam int OccW  = 9;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_REMOVE  = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [KeyW-1:0] key;
    logic [NameW-1:0]       name;
  } entry_t;

endpackage

### rtl/ternary_min_heap_queue.sv
// ----------------------------------------------------------------------------
// ternary_min_heap_queue: d-ary min-heap priority queue of key/name pairs
// Entries live in one synchronous RAM; sifts move a hole rather than swap.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one item: opcode, item_key,
//   item_name, position. Output channel (out_valid/out_ready) returns one
//   item per input: out_name, out_key, status, occupancy.
//   One item is worked on at a time; in_ready is high only while idle.
//   Insert climbs from the new last slot, reading and comparing one parent
//   per level, and stops at the root; extract and remove read the slot and
//   the last entry, then climb the same way or descend, reading each child
//   of a level in turn before deciding. A sift is bound by the single RAM
//   read port. Flagged cases (full, empty, out of range) skip the RAM;
//   in_ready returns as each result is loaded into the output register.
//   The result sits in an output register; a new item may be accepted while
//   it waits, but the next result holds until the receiver takes the last.
//   Reset empties the queue; the RAM itself is not cleared, only slots
//   below the occupancy are ever used.
// ----------------------------------------------------------------------------
module ternary_min_heap_queue
  import tmhq_pkg::*;
#(
  parameter int CAPACITY = 256,
  parameter int ARITY    = 3
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             opcode,
  input  logic signed [KeyW-1:0] item_key,
  input  logic [NameW-1:0]       item_name,
  input  logic [PosW-1:0]        position,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [NameW-1:0]       out_name,
  output logic signed [KeyW-1:0] out_key,
  output logic [1:0]             status,
  output logic [OccW-1:0]        occupancy
);

  localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int XW0 = $clog2(CAPACITY * ARITY + 2);
  localparam int XW  = (XW0 > PosW) ? XW0 : PosW;
  localparam int NW  = $clog2(ARITY + 1);

  // parent index by reciprocal multiplication, exact for any XW-bit value
  localparam int PSH    = XW + $clog2(ARITY);
  localparam int PRECIP = ((1 << PSH) + ARITY - 1) / ARITY;
  localparam int PRW    = XW + PSH + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_SLOT, S_RD_LAST, S_GOT_LAST, S_RM_CMP,
    S_UP_RD, S_UP_CMP, S_DN_START, S_DN_RD, S_DONE
  } state_t;

  state_t            state;
  entry_t            mem [CAPACITY];
  entry_t            rdata;
  logic [AW-1:0]     ra;
  logic              we;
  logic [AW-1:0]     wa;
  entry_t            wd;

  logic [XW-1:0]     count;
  logic [XW-1:0]     hole;
  logic [XW-1:0]     rd_q;
  logic [XW-1:0]     best_idx;
  entry_t            best;
  entry_t            x;
  logic [NW-1:0]     nread;
  entry_t            res;
  status_t           res_st;

  logic [PRW-1:0]    parent_prod;
  logic [XW-1:0]     parent;
  logic [XW-1:0]     first_child;
  logic [XW-1:0]     slot;
  logic [XW-1:0]     last_idx;
  logic [XW-1:0]     next_child;
  logic              take_new;
  entry_t            best_next;
  logic [XW-1:0]     best_idx_next;
  logic              more;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata <= mem[ra];
  end

  assign parent_prod = PRW'(hole - XW'(1)) * PRW'(PRECIP);
  assign parent      = parent_prod[PSH +: XW];
  assign first_child = XW'(hole * ARITY + 1);
  assign slot        = (opcode_t'(opcode) == OP_EXTRACT) ? '0 : XW'(position);
  assign last_idx    = count - XW'(1);
  assign next_child  = rd_q + XW'(1);

  // running minimum over the children read so far; the lower-indexed child wins ties
  assign take_new      = (nread == NW'(1)) || (rdata.key < best.key);
  assign best_next     = take_new ? rdata : best;
  assign best_idx_next = take_new ? rd_q : best_idx;
  assign more          = (nread < NW'(ARITY)) && (next_child < count);

  assign in_ready = (state == S_IDLE);

  always_comb begin
    ra = rd_q[AW-1:0];
    we = 1'b0;
    wa = hole[AW-1:0];
    wd = x;
    case (state)
      S_RD_SLOT:  ra = hole[AW-1:0];
      S_RD_LAST:  ra = last_idx[AW-1:0];
      S_GOT_LAST: ra = parent[AW-1:0];
      S_RM_CMP: begin
        if (x.key < rdata.key) begin
          we = 1'b1;
          wd = rdata;
        end
      end
      S_UP_RD: begin
        ra = parent[AW-1:0];
        we = (hole == '0);
      end
      S_UP_CMP: begin
        we = 1'b1;
        wd = (x.key < rdata.key) ? rdata : x;
      end
      S_DN_START: begin
        ra = first_child[AW-1:0];
        we = (first_child >= count);
      end
      S_DN_RD: begin
        ra = next_child[AW-1:0];
        if (!more) begin
          we = 1'b1;
          wd = (best_next.key < x.key) ? best_next : x;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            res    <= '0;
            res_st <= ST_OK;
            state  <= S_DONE;
            case (opcode_t'(opcode))
              OP_INSERT: begin
                if (count >= XW'(CAPACITY)) begin
                  res_st <= ST_FULL;
                end else begin
                  x.key  <= item_key;
                  x.name <= item_name;
                  hole   <= count;
                  count  <= count + XW'(1);
                  state  <= S_UP_RD;
                end
              end
              OP_EXTRACT, OP_REMOVE: begin
                if (count == '0) begin
                  res_st <= ST_EMPTY;
                end else if (slot >= count) begin
                  res_st <= ST_RANGE;
                end else begin
                  hole  <= slot;
                  state <= S_RD_SLOT;
                end
              end
              default: ;
            endcase
          end
        end
        S_RD_SLOT: state <= S_RD_LAST;
        S_RD_LAST: begin
          res   <= rdata;
          state <= S_GOT_LAST;
        end
        S_GOT_LAST: begin
          x     <= rdata;
          count <= last_idx;
          if (hole == last_idx) begin
            state <= S_DONE;
          end else if (hole == '0) begin
            state <= S_DN_START;
          end else begin
            state <= S_RM_CMP;
          end
        end
        S_RM_CMP: begin
          if (x.key < rdata.key) begin
            hole  <= parent;
            state <= S_UP_RD;
          end else begin
            state <= S_DN_START;
          end
        end
        S_UP_RD: begin
          state <= (hole == '0) ? S_DONE : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (x.key < rdata.key) begin
            hole  <= parent;
            state <= S_UP_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_DN_START: begin
          if (first_child >= count) begin
            state <= S_DONE;
          end else begin
            rd_q  <= first_child;
            nread <= NW'(1);
            state <= S_DN_RD;
          end
        end
        S_DN_RD: begin
          best     <= best_next;
          best_idx <= best_idx_next;
          if (more) begin
            rd_q  <= next_child;
            nread <= nread + NW'(1);
          end else if (best_next.key < x.key) begin
            hole  <= best_idx_next;
            state <= S_DN_START;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_name  <= res.name;
            out_key   <= res.key;
            status    <= res_st;
            occupancy <= OccW'(count);
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
